### hdl/asrd_pkg.sv
// ----------------------------------------------------------------------------
// asrd_pkg
// Shared types and constants for the analog stick radial dead zone block.
// ----------------------------------------------------------------------------
package asrd_pkg;

  localparam int SLOWDOWN    = 16;
  localparam int REM_W       = $clog2(SLOWDOWN) + 1;
  localparam int DZ_W        = 15;
  localparam int RAW_W       = 8;
  localparam int FUNC_W      = 3;
  localparam int LEVEL_W     = 13;
  localparam int LEVEL_LIMIT = 2048;
  localparam int CENTRE      = 127;
  localparam int FULL_SCALE  = 32768;

  localparam int C_W        = 17;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 16;
  localparam int RR_W       = 20;
  localparam int PROD_W     = 32;
  localparam int NUM_W      = 47;
  localparam int DEN_W      = 31;
  localparam int Q_W        = 31;
  localparam int SCL_W      = 32;
  localparam int CNT_W      = 6;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int NUM_AXES   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LX   = 3'd0,
    FUNC_LY   = 3'd1,
    FUNC_RX   = 3'd2,
    FUNC_RY   = 3'd3,
    FUNC_NONE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_SQUARE,
    LN_ROOT,
    LN_PROD,
    LN_DIV,
    LN_DONE
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_OUT
  } top_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  function automatic logic signed [C_W-1:0] centre_byte(input logic [RAW_W-1:0] b);
    logic signed [C_W-1:0] d;
    d = $signed({{(C_W-RAW_W){1'b0}}, b}) - C_W'(CENTRE);
    return d <<< 8;
  endfunction

endpackage

### hdl/analog_stick_radial_deadzone_top.sv
// ----------------------------------------------------------------------------
// analog_stick_radial_deadzone_top
// Scaled radial dead zone for two analog sticks, one poll per transfer.
// ----------------------------------------------------------------------------
// A connected poll runs both sticks in parallel lanes, each with a 16-step
// square root followed by a 47-step restoring divider. When both sticks fall
// inside the dead zone the dividers are skipped. A disconnected poll returns
// 0. One poll is in flight at a time; the result register lets the next poll
// be taken while a result still waits.
module analog_stick_radial_deadzone_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // left_x_raw, left_y_raw, right_x_raw, right_y_raw
  input  logic [3:0]  in_tuser,   // pad_connected, func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // axis_level[12:0], zero pad
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);
  import asrd_pkg::*;

  top_state_t           state_r, state_nxt;
  logic [DZ_W-1:0]      dz_r;
  logic                 conn_r;
  logic [FUNC_W-1:0]    func_r;
  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 accept, start, load, lanes_done;
  lane_stat_t           stat_l, stat_r;
  logic signed [SCL_W-1:0] lx, ly, rx, ry;
  logic signed [LEVEL_W-1:0] level;

  assign accept     = in_tvalid && in_tready;
  assign start      = accept && in_tuser[0];
  assign lanes_done = stat_l.done && stat_r.done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:  if (accept) state_nxt = in_tuser[0] ? T_RUN : T_OUT;
      T_RUN:   if (lanes_done) state_nxt = T_OUT;
      T_OUT:   if (!out_valid_r || out_tready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_tready = state_r == T_IDLE;
    load      = (state_r == T_OUT) && (!out_valid_r || out_tready);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-LEVEL_W){1'b0}}, out_level_r};

  asrd_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ack   (load),
    .x_in  (centre_byte(in_tdata[7:0])),
    .y_in  (centre_byte(in_tdata[15:8])),
    .dz_in (dz_r),
    .stat  (stat_l),
    .x_out (lx),
    .y_out (ly)
  );

  asrd_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ack   (load),
    .x_in  (centre_byte(in_tdata[23:16])),
    .y_in  (centre_byte(in_tdata[31:24])),
    .dz_in (dz_r),
    .stat  (stat_r),
    .x_out (rx),
    .y_out (ry)
  );

  asrd_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (load && conn_r),
    .func  (func_r),
    .lx    (lx),
    .ly    (ly),
    .rx    (rx),
    .ry    (ry),
    .level (level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      dz_r        <= DZ_W'(7680);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) dz_r <= cfg_wr_data;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      conn_r <= in_tuser[0];
      func_r <= in_tuser[3:1];
    end
    if (load) out_level_r <= conn_r ? level : '0;
  end

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_level_r) <= LEVEL_LIMIT &&
                     $signed(out_level_r) >= -LEVEL_LIMIT))
    else $error("axis level out of range");
  a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_IDLE |-> !stat_l.busy && !stat_r.busy)
    else $error("lane busy while idle");
  a_disc_no_lane: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tuser[0] |=> !stat_l.busy && !stat_r.busy)
    else $error("lane started on disconnected poll");
`endif

endmodule

### hdl/asrd_lane.sv
// ----------------------------------------------------------------------------
// asrd_lane
// One stick: magnitude by digit-serial square root, then radial rescale of
// both axes by two restoring dividers that run side by side.
// ----------------------------------------------------------------------------
module asrd_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             ack,
  input  logic signed [asrd_pkg::C_W-1:0]  x_in,
  input  logic signed [asrd_pkg::C_W-1:0]  y_in,
  input  logic [asrd_pkg::DZ_W-1:0]        dz_in,
  output asrd_pkg::lane_stat_t             stat,
  output logic signed [asrd_pkg::SCL_W-1:0] x_out,
  output logic signed [asrd_pkg::SCL_W-1:0] y_out
);
  import asrd_pkg::*;

  lane_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  mag_x_r, mag_y_r;
  logic              neg_x_r, neg_y_r, zero_r;
  logic [DZ_W-1:0]   dz_r;
  logic [SQ_W-1:0]   rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [RR_W-1:0]   rrem_r;
  logic [NUM_W-1:0]  num_x_r, num_y_r, quo_x_r, quo_y_r;
  logic [DEN_W-1:0]  den_r, rem_x_r, rem_y_r;

  logic [RR_W-1:0]   rt, rtrial;
  logic              rgo;
  logic [DEN_W:0]    tx, ty;
  logic              gx, gy;
  logic              skip;
  logic [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]  span;
  logic [Q_W-1:0]    qx, qy;

  always_comb begin
    rt     = {rrem_r[RR_W-3:0], rad_r[SQ_W-1 -: 2]};
    rtrial = {{(RR_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    rgo    = rt >= rtrial;
    tx     = {rem_x_r, num_x_r[NUM_W-1]};
    ty     = {rem_y_r, num_y_r[NUM_W-1]};
    gx     = tx >= {1'b0, den_r};
    gy     = ty >= {1'b0, den_r};
    skip   = (root_r == '0) || (root_r < {1'b0, dz_r});
    diff   = root_r - {1'b0, dz_r};
    span   = MAG_W'(FULL_SCALE) - {1'b0, dz_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LN_IDLE:   if (start) state_nxt = LN_SQUARE;
      LN_SQUARE: state_nxt = LN_ROOT;
      LN_ROOT:   if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = LN_PROD;
      LN_PROD:   state_nxt = skip ? LN_DONE : LN_DIV;
      LN_DIV:    if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = LN_DONE;
      LN_DONE:   if (ack) state_nxt = LN_IDLE;
      default:   state_nxt = LN_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = state_r != LN_IDLE;
    stat.done = state_r == LN_DONE;
    qx        = quo_x_r[Q_W-1:0];
    qy        = quo_y_r[Q_W-1:0];
    x_out     = zero_r ? '0 : (neg_x_r ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
    y_out     = zero_r ? '0 : (neg_y_r ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      LN_IDLE: begin
        if (start) begin
          neg_x_r <= x_in < 0;
          neg_y_r <= y_in < 0;
          mag_x_r <= MAG_W'(x_in < 0 ? -x_in : x_in);
          mag_y_r <= MAG_W'(y_in < 0 ? -y_in : y_in);
          dz_r    <= dz_in;
        end
      end
      LN_SQUARE: begin
        rad_r  <= SQ_W'(mag_x_r * mag_x_r) + SQ_W'(mag_y_r * mag_y_r);
        root_r <= '0;
        rrem_r <= '0;
        cnt_r  <= '0;
      end
      LN_ROOT: begin
        rad_r  <= rad_r << 2;
        rrem_r <= rgo ? rt - rtrial : rt;
        root_r <= {root_r[ROOT_W-2:0], rgo};
        cnt_r  <= cnt_r + 1'b1;
      end
      LN_PROD: begin
        zero_r  <= skip;
        num_x_r <= NUM_W'(PROD_W'(mag_x_r * diff)) << 15;
        num_y_r <= NUM_W'(PROD_W'(mag_y_r * diff)) << 15;
        den_r   <= DEN_W'(PROD_W'(root_r * span));
        rem_x_r <= '0;
        rem_y_r <= '0;
        quo_x_r <= '0;
        quo_y_r <= '0;
        cnt_r   <= '0;
      end
      LN_DIV: begin
        num_x_r <= num_x_r << 1;
        num_y_r <= num_y_r << 1;
        rem_x_r <= gx ? DEN_W'(tx - {1'b0, den_r}) : DEN_W'(tx);
        rem_y_r <= gy ? DEN_W'(ty - {1'b0, den_r}) : DEN_W'(ty);
        quo_x_r <= {quo_x_r[NUM_W-2:0], gx};
        quo_y_r <= {quo_y_r[NUM_W-2:0], gy};
        cnt_r   <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/asrd_merge.sv
// ----------------------------------------------------------------------------
// asrd_merge
// Combine the lane results: slow down each axis with its carried remainder,
// pick the requested axis and clamp it.
// ----------------------------------------------------------------------------
module asrd_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                upd,
  input  logic [asrd_pkg::FUNC_W-1:0]         func,
  input  logic signed [asrd_pkg::SCL_W-1:0]   lx,
  input  logic signed [asrd_pkg::SCL_W-1:0]   ly,
  input  logic signed [asrd_pkg::SCL_W-1:0]   rx,
  input  logic signed [asrd_pkg::SCL_W-1:0]   ry,
  output logic signed [asrd_pkg::LEVEL_W-1:0] level
);
  import asrd_pkg::*;

  localparam int ACC_W = SCL_W + 1;
  localparam logic signed [ACC_W-1:0] SLOW_S = ACC_W'(SLOWDOWN);
  localparam logic signed [ACC_W-1:0] LIM_S  = ACC_W'(LEVEL_LIMIT);

  logic signed [REM_W-1:0] rem_r [NUM_AXES];
  logic signed [SCL_W-1:0] v     [NUM_AXES];
  logic signed [ACC_W-1:0] acc   [NUM_AXES];
  logic signed [ACC_W-1:0] quo   [NUM_AXES];
  logic signed [ACC_W-1:0] md    [NUM_AXES];
  logic signed [ACC_W-1:0] sel;

  always_comb begin
    v[0] = lx;
    v[1] = ly;
    v[2] = rx;
    v[3] = ry;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc[i] = ACC_W'(rem_r[i]) + ACC_W'(v[i]);
      quo[i] = acc[i] / SLOW_S;
      md[i]  = acc[i] % SLOW_S;
    end
    case (func)
      FUNC_LX: sel = quo[0];
      FUNC_LY: sel = quo[1];
      FUNC_RX: sel = quo[2];
      FUNC_RY: sel = quo[3];
      default: sel = '0;
    endcase
    if (sel > LIM_S) begin
      level = LEVEL_W'(LIM_S);
    end else if (sel < -LIM_S) begin
      level = LEVEL_W'(-LIM_S);
    end else begin
      level = LEVEL_W'(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) rem_r[i] <= '0;
    end else if (upd) begin
      for (int i = 0; i < NUM_AXES; i++) rem_r[i] <= md[i][REM_W-1:0];
    end
  end

endmodule
